/* hw/rtl/assert_macros.svh */
// assertion helpers used by the bound checker, firq15_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

// clocked check that also holds across reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("check failed");

`endif

/* hw/rtl/firq15_pkg.sv */
`default_nettype none

package firq15_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 32;
    localparam int TABLE_TAPS = 19;
    localparam int TAB_IDX_W  = 5;

    // sample queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;

    // head of the sample queue as seen by the back end
    typedef struct packed {
        logic    valid;
        t_sample sample;
    } t_queue_out;

    // low-pass taps, q15, symmetric
    localparam t_sample COEF_TABLE [TABLE_TAPS] = '{
        16'sd399,   -16'sd295,  -16'sd944,  -16'sd1554, -16'sd1502,
        -16'sd284,  16'sd2112,  16'sd5061,  16'sd7503,  16'sd8450,
        16'sd7503,  16'sd5061,  16'sd2112,  -16'sd284,  -16'sd1502,
        -16'sd1554, -16'sd944,  -16'sd295,  16'sd399
    };

    // taps past the end of the table weigh zero
    function automatic t_sample coef_at(input int j);
        t_sample c;
        c = '0;
        if (j >= 0 && j < TABLE_TAPS) begin
            c = COEF_TABLE[j[TAB_IDX_W-1:0]];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/firq15_front.sv */
`default_nettype none

module firq15_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire firq15_pkg::t_sample    i_sample_in,
    output firq15_pkg::t_queue_out      o_queue,
    input  wire logic                   i_pop
);
    import firq15_pkg::*;

    t_sample               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count,  n_count;
    logic                  w_push;

    // accept while the queue has room
    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign w_push  = i_valid && o_ready;

    // head of queue toward the back end
    assign o_queue.valid  = (r_count != '0);
    assign o_queue.sample = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = r_wr_ptr + QUEUE_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + QUEUE_AW'(1);
        end
        if (w_push && !i_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (!w_push && i_pop) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_sample_in;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/firq15_back.sv */
`default_nettype none

module firq15_back #(
    parameter int TAP_COUNT     = 19,
    parameter int FRACTION_BITS = 15
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire firq15_pkg::t_queue_out i_queue,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output firq15_pkg::t_sample         o_filtered_sample,
    output logic                        o_wrapped
);
    import firq15_pkg::*;

    localparam int LANES = (TAP_COUNT > 1) ? TAP_COUNT - 1 : 1;

    // transposed delay line: each lane holds a partial sum
    t_acc    r_lane [LANES];
    t_acc    n_lane [LANES];
    t_acc    w_sum;
    t_acc    w_shift;
    logic    w_wrap;
    logic    r_valid;
    t_sample r_sample;
    logic    r_wrapped;

    // take the next sample whenever the output register frees up
    assign o_pop = i_queue.valid && (!r_valid || i_ready);

    // lane updates, one constant multiply per lane, plus an add of the next lane for all but the last
    always_comb begin
        t_acc w_prod;
        w_prod = '0;
        for (int k = 0; k < LANES; k++) begin
            n_lane[k] = r_lane[k];
            if (o_pop && k < TAP_COUNT - 1) begin
                w_prod = t_acc'(coef_at(k + 1)) * t_acc'(i_queue.sample);
                if (k < TAP_COUNT - 2) begin
                    n_lane[k] = w_prod + r_lane[k + 1];
                end else begin
                    n_lane[k] = w_prod;
                end
            end
        end
    end

    // newest tap plus the head lane, then scale and range check
    always_comb begin
        w_sum = t_acc'(coef_at(0)) * t_acc'(i_queue.sample);
        if (TAP_COUNT > 1) begin
            w_sum = w_sum + r_lane[0];
        end
        w_shift = w_sum >>> FRACTION_BITS;
        w_wrap  = !((&w_shift[ACC_W-1:SAMPLE_W-1]) || (~|w_shift[ACC_W-1:SAMPLE_W-1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                r_lane[k] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            r_lane <= n_lane;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample  <= w_shift[SAMPLE_W-1:0];
            r_wrapped <= w_wrap;
        end
    end

    assign o_valid           = r_valid;
    assign o_filtered_sample = r_sample;
    assign o_wrapped         = r_wrapped;

endmodule

`default_nettype wire

/* hw/rtl/fir_filter_q15_19tap_core.sv */
// Streaming low-pass FIR, signed 16-bit samples, q15 coefficients.
// Input channel: i_valid / o_ready with i_sample_in; an item is taken at a
// clock edge where both are high. Output channel: o_valid / i_ready with
// o_filtered_sample and o_wrapped, one result item per input item, in order.
// o_wrapped flags a scaled sum outside the signed 16-bit range, in which
// case o_filtered_sample holds its low 16 bits.
// An accepted item is written into the queue; once the output register is
// free or being taken, it is popped and filtered into the output register,
// where its result shows until taken. Throughput: one item per cycle while
// i_ready stays high; samples pass a 4-entry queue into a transposed
// multiply-add line whose lanes all advance in the same cycle.
// When the receiver stalls the result holds in the output register, the
// queue keeps taking items until full, then o_ready drops.
// Reset (i_rst_n low, synchronous) clears the sample history to zero and
// empties the queue and output register; no clearing pass is needed.

`default_nettype none

module fir_filter_q15_19tap_core #(
    parameter int TAP_COUNT     = 19,
    parameter int FRACTION_BITS = 15
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire firq15_pkg::t_sample    i_sample_in,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output firq15_pkg::t_sample         o_filtered_sample,
    output logic                        o_wrapped
);
    import firq15_pkg::*;

    t_queue_out w_queue;
    logic       w_pop;

    // intake and sample queue
    firq15_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample_in (i_sample_in),
        .o_queue     (w_queue),
        .i_pop       (w_pop)
    );

    // filter datapath and output register
    firq15_back #(
        .TAP_COUNT     (TAP_COUNT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_queue           (w_queue),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_filtered_sample (o_filtered_sample),
        .o_wrapped         (o_wrapped)
    );

endmodule

`default_nettype wire

/* hw/rtl/firq15_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module firq15_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire firq15_pkg::t_sample o_filtered_sample,
    input wire logic                o_wrapped
);
    import firq15_pkg::*;

    logic [3:0]          r_inflight;
    logic                w_in_acc;
    logic                w_out_acc;
    logic [SAMPLE_W:0]   w_result;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign w_result  = {o_filtered_sample, o_wrapped};

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (w_in_acc && !w_out_acc) begin
            r_inflight <= r_inflight + 4'd1;
        end else if (!w_in_acc && w_out_acc) begin
            r_inflight <= r_inflight - 4'd1;
        end
    end

    // reset empties the output
    `ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

    // a stalled result holds
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(w_result))

    // no result without an item behind it
    `ASSERT_CLK(a_no_extra, i_clk, i_rst_n, o_valid |-> r_inflight != 4'd0)

    // queue plus output register bound what is in flight
    `ASSERT_CLK(a_capacity, i_clk, i_rst_n, r_inflight <= 4'(QUEUE_DEPTH + 1))

endmodule

bind fir_filter_q15_19tap_core firq15_checker u_checker (.*);

`default_nettype wire

/* tb/sv/fir_q15_checker.sv */
// watches both channels of the q15 low-pass core, predicts every filtered
// sample from its own copy of the delay line and compares in order
module fir_q15_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire firq15_pkg::t_sample i_sample,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire firq15_pkg::t_sample i_filtered,
    input  wire logic                i_wrapped,
    output int                       o_mismatches,
    output int                       o_pending,
    output int                       o_taken,
    output int                       o_checked,
    output int                       o_wrap_seen
);
    import firq15_pkg::*;

    localparam int N_TAPS    = 19;
    localparam int FRAC_BITS = 15;
    localparam int MAX_SHOWN = 10;

    // symmetric low-pass taps, q15, index 0 weighs the newest sample
    localparam t_sample LOWPASS_Q15 [N_TAPS] = '{
        16'sd399,   -16'sd295,  -16'sd944,  -16'sd1554, -16'sd1502,
        -16'sd284,  16'sd2112,  16'sd5061,  16'sd7503,  16'sd8450,
        16'sd7503,  16'sd5061,  16'sd2112,  -16'sd284,  -16'sd1502,
        -16'sd1554, -16'sd944,  -16'sd295,  16'sd399
    };

    typedef struct packed {
        t_sample value;
        logic    wrapped;
    } t_filtered;

    t_sample   delay_line [N_TAPS-1];
    t_filtered filtered_q [$];

    int mismatches = 0;
    int taken      = 0;
    int checked    = 0;
    int wrap_seen  = 0;

    // dot product over 32-bit wrapping sum, floor shift, low 16 bits kept
    function automatic t_filtered fir_predict(input t_sample x);
        t_acc      acc;
        t_acc      scaled;
        t_filtered r;
        acc = t_acc'(LOWPASS_Q15[0]) * t_acc'(x);
        for (int j = 1; j < N_TAPS; j++) begin
            acc += t_acc'(LOWPASS_Q15[j]) * t_acc'(delay_line[j-1]);
        end
        scaled    = acc >>> FRAC_BITS;
        r.value   = scaled[15:0];
        r.wrapped = (scaled[31:15] != '0) && (scaled[31:15] != '1);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_filtered want;
        if (!i_rst_n) begin
            foreach (delay_line[k]) delay_line[k] = '0;
            filtered_q.delete();
        end else begin
            // compare a result item with the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (filtered_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("%0t: unexpected result %0d wrapped %b",
                                 $realtime, i_filtered, i_wrapped);
                    end
                end else begin
                    want = filtered_q.pop_front();
                    checked++;
                    if (want.wrapped) wrap_seen++;
                    if (i_filtered !== want.value || i_wrapped !== want.wrapped) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN) begin
                            $display("%0t: result %0d: expected %0d wrapped %b, got %0d wrapped %b",
                                     $realtime, checked, want.value, want.wrapped,
                                     i_filtered, i_wrapped);
                        end
                    end
                end
            end
            // predict the result of an accepted sample, then shift it in
            if (i_in_valid && i_in_ready) begin
                filtered_q.push_back(fir_predict(i_sample));
                for (int k = N_TAPS - 2; k > 0; k--) delay_line[k] = delay_line[k-1];
                delay_line[0] = i_sample;
                taken++;
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= filtered_q.size();
        o_taken      <= taken;
        o_checked    <= checked;
        o_wrap_seen  <= wrap_seen;
    end

endmodule

/* tb/sv/tb.sv */
// stimulus and verdict for the q15 low-pass core; prediction and compare
// live in the checker instantiated beside the core
module tb;
    import firq15_pkg::*;

    localparam int      RANDOM_ITEMS = 1300;
    localparam int      SETTLE_CYCLES = 10;
    // taps with a negative weight, bit j for tap j
    localparam bit [18:0] NEG_TAPS = 19'b0111110000000111110;

    logic    i_clk      = 1'b0;
    logic    i_rst_n    = 1'b0;
    logic    in_valid   = 1'b0;
    logic    out_ready  = 1'b0;
    t_sample in_sample  = '0;
    logic    in_ready;
    logic    out_valid;
    t_sample out_sample;
    logic    out_wrapped;

    int mismatches;
    int pending;
    int taken;
    int checked;
    int wrap_seen;

    int items_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    fir_filter_q15_19tap_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_sample_in       (in_sample),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_filtered_sample (out_sample),
        .o_wrapped         (out_wrapped)
    );

    fir_q15_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_sample     (in_sample),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_filtered   (out_sample),
        .i_wrapped    (out_wrapped),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_taken      (taken),
        .o_checked    (checked),
        .o_wrap_seen  (wrap_seen)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver stalls in runs: always ready, held off, coin flip, alternating
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 1) ? $urandom_range(1, 12) : $urandom_range(1, 40);
        end
        stall_left--;
        case (stall_mode)
            0: begin
                out_ready <= 1'b1;
            end
            1: begin
                out_ready <= 1'b0;
            end
            2: begin
                out_ready <= $urandom_range(0, 1);
            end
            default: begin
                out_ready <= stall_left[0];
            end
        endcase
    end

    // present one sample until taken, then maybe open a gap between bursts
    task automatic send_item(input t_sample s);
        int gap;
        @(negedge i_clk);
        in_valid  <= 1'b1;
        in_sample <= s;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(0, 20);
        end
    endtask

    // stop sending and wait until every predicted result has been compared
    task automatic wait_drained();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // sample whose sign follows tap p, large magnitude, polarity flips all
    function automatic t_sample sign_matched(input int p, input bit flip, input bit full);
        int mag;
        mag = full ? 32767 : $urandom_range(16000, 32767);
        if (NEG_TAPS[p % 19] ^ flip) return t_sample'(-mag - int'(full));
        return t_sample'(mag);
    endfunction

    initial begin
        int      kind;
        int      len;
        bit      flip;
        t_sample extremes [5];
        extremes = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff, 16'sh0001};

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // impulse, then a sign-matched full-scale run that wraps once filled
        send_item(16'sh7fff);
        for (int p = 0; p < 19; p++) send_item(sign_matched(p, 1'b0, 1'b1));
        foreach (extremes[k]) send_item(extremes[k]);
        wait_drained();

        // random segments of differing character
        while (items_sent < RANDOM_ITEMS + 25) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                len = $urandom_range(5, 40);
                repeat (len) send_item(t_sample'($urandom()));
            end else if (kind <= 6) begin
                flip = $urandom_range(0, 1);
                len  = $urandom_range(19, 40);
                for (int p = 0; p < len; p++) begin
                    send_item(sign_matched(p, flip, $urandom_range(0, 3) == 0));
                end
            end else if (kind == 7) begin
                len = $urandom_range(3, 12);
                repeat (len) send_item(extremes[$urandom_range(0, 4)]);
            end else if (kind == 8) begin
                len = $urandom_range(5, 30);
                repeat (len) send_item(t_sample'($urandom_range(0, 128) - 64));
            end else begin
                // flush the line with zeros, then a lone pulse
                repeat (19) send_item('0);
                send_item(extremes[$urandom_range(0, 1)]);
            end
            if ($urandom_range(0, 19) == 0) wait_drained();
        end

        @(negedge i_clk);
        in_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d samples filtered, %0d outputs compared, %0d of them wrapped",
                 taken, checked, wrap_seen);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/firq15_pkg.sv
hw/rtl/firq15_front.sv
hw/rtl/firq15_back.sv
hw/rtl/fir_filter_q15_19tap_core.sv
hw/rtl/firq15_checker.sv
tb/sv/fir_q15_checker.sv
tb/sv/tb.sv
